### design/bounded_priority_queue_assert.svh
// assertion macros used by the checker file
`ifndef BOUNDED_PRIORITY_QUEUE_ASSERT_SVH
`define BOUNDED_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define BPQ_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define BPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/bpq_pkg.sv
// types and codes of the bounded priority queue
package bpq_pkg;

  localparam logic [1:0] MODE_ENQ    = 2'd0;
  localparam logic [1:0] MODE_DEQ    = 2'd1;
  localparam logic [1:0] MODE_PEEK   = 2'd2;
  // reserved code, the block leaves its state alone
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic        [1:0]  mode;
    logic signed [31:0] item_value;
    logic signed [31:0] item_rank;
  } req_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] front_value;
    logic signed [31:0] front_rank;
    logic        [4:0]  fill_level;
  } rsp_t;

  typedef struct packed {
    logic enq;
    logic deq;
    logic live;
  } cell_ctrl_t;

endpackage

### design/bpq_cell.sv
// one storage cell of the sorted chain
module bpq_cell (
  input  logic               clk,
  input  bpq_pkg::cell_ctrl_t ctrl,
  input  logic signed [31:0] new_value,
  input  logic signed [31:0] new_rank,
  input  logic               left_keep,
  input  logic signed [31:0] left_value,
  input  logic signed [31:0] left_rank,
  input  logic signed [31:0] right_value,
  input  logic signed [31:0] right_rank,
  output logic signed [31:0] value,
  output logic signed [31:0] rank,
  output logic               keep
);

  // on an enqueue, a live entry stays put unless the new item outranks it
  assign keep = ctrl.live && !(new_rank > rank);

  always_ff @(posedge clk) begin
    if (ctrl.deq) begin
      value <= right_value;
      rank  <= right_rank;
    end else if (ctrl.enq && !keep) begin
      if (left_keep) begin
        value <= new_value;
        rank  <= new_rank;
      end else begin
        value <= left_value;
        rank  <= left_rank;
      end
    end
  end

endmodule

### design/bounded_priority_queue.sv
// top level of the bounded priority queue
// Bounded priority queue kept as a row of CAPACITY cells sorted by rank,
// highest first, equal ranks in arrival order. For each request (enqueue,
// dequeue, peek), every cell compares its rank with the new item in
// parallel and shifts toward its neighbor in the same edge, so a request
// is accepted every cycle unless the output stalls. The result is registered
// and appears in the cycle after the request is accepted; a new request is
// taken while the output register is empty or its item is being taken. Only
// the first fill_level cells are live; dead cells hold stale data.
module bounded_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bpq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bpq_pkg::rsp_t rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [CW+4:0]   fill_ext;
  logic            accept;
  logic            full;
  logic            empty;
  logic            do_enq;
  logic            do_deq;
  bpq_pkg::rsp_t   rsp_next;

  logic signed [31:0] cell_value [CAPACITY];
  logic signed [31:0] cell_rank  [CAPACITY];
  logic               cell_keep  [CAPACITY];

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);
  assign do_enq    = accept && (req.mode == bpq_pkg::MODE_ENQ) && !full;
  assign do_deq    = accept && (req.mode == bpq_pkg::MODE_DEQ) && !empty;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    bpq_pkg::cell_ctrl_t ctrl;
    logic               lk;
    logic signed [31:0] lv;
    logic signed [31:0] lr;
    logic signed [31:0] rv;
    logic signed [31:0] rr;

    assign ctrl.enq  = do_enq;
    assign ctrl.deq  = do_deq;
    assign ctrl.live = (count > CW'(i));

    if (i == 0) begin : g_head
      assign lk = 1'b1;
      assign lv = req.item_value;
      assign lr = req.item_rank;
    end else begin : g_body
      assign lk = cell_keep[i-1];
      assign lv = cell_value[i-1];
      assign lr = cell_rank[i-1];
    end

    // the tail cell refills from itself on a dequeue; it becomes dead anyway
    if (i == CAPACITY - 1) begin : g_tail
      assign rv = cell_value[i];
      assign rr = cell_rank[i];
    end else begin : g_inner
      assign rv = cell_value[i+1];
      assign rr = cell_rank[i+1];
    end

    bpq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .new_value   (req.item_value),
      .new_rank    (req.item_rank),
      .left_keep   (lk),
      .left_value  (lv),
      .left_rank   (lr),
      .right_value (rv),
      .right_rank  (rr),
      .value       (cell_value[i]),
      .rank        (cell_rank[i]),
      .keep        (cell_keep[i])
    );
  end

  always_comb begin
    count_next           = count;
    rsp_next.status      = bpq_pkg::STATUS_OK;
    rsp_next.front_value = '0;
    rsp_next.front_rank  = '0;
    unique case (req.mode)
      bpq_pkg::MODE_ENQ: begin
        if (full) begin
          rsp_next.status = bpq_pkg::STATUS_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      bpq_pkg::MODE_DEQ, bpq_pkg::MODE_PEEK: begin
        if (empty) begin
          rsp_next.status = bpq_pkg::STATUS_EMPTY;
        end else begin
          rsp_next.front_value = cell_value[0];
          rsp_next.front_rank  = cell_rank[0];
          if (req.mode == bpq_pkg::MODE_DEQ) begin
            count_next = count - CW'(1);
          end
        end
      end
      default: begin
      end
    endcase
    // fill level is the updated count modulo 32
    fill_ext            = {5'd0, count_next};
    rsp_next.fill_level = fill_ext[4:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

### design/bpq_checker.sv
// port-level checker for the bounded priority queue, with its bind
`include "bounded_priority_queue_assert.svh"

module bpq_checker #(
  parameter int CAPACITY = 16
) (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input bpq_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input bpq_pkg::rsp_t rsp
);

  localparam logic [4:0] FULL_LEVEL = 5'(CAPACITY % 32);

  `BPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "result item dropped or changed while stalled")
  `BPQ_ASSERT(a_full_level, rsp_valid && (rsp.status == bpq_pkg::STATUS_FULL), rsp.fill_level == FULL_LEVEL, "full status with fill level below capacity")
  `BPQ_ASSERT(a_empty_zero, rsp_valid && (rsp.status == bpq_pkg::STATUS_EMPTY), (rsp.fill_level == 5'd0) && (rsp.front_value == '0) && (rsp.front_rank == '0), "empty status with nonzero fields")
  `BPQ_ASSERT_NEXT(a_rsp_follows, req_valid && req_ready, rsp_valid, "accepted request gave no result item")

endmodule

bind bounded_priority_queue bpq_checker #(.CAPACITY(CAPACITY)) u_bpq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

### test/bounded_priority_queue_tb.sv
// testbench of the bounded priority queue: shadow queue prediction, random idling and stalls
`timescale 1ns / 1ps

module bounded_priority_queue_tb;

  localparam int DEPTH = 16;
  localparam int HOLD_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 2000;
  localparam int PHASE_LEN = 100;
  localparam int MAX_SHOWN = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  bpq_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  bpq_pkg::rsp_t rsp;

  // shadow copy of the sorted storage, front at index 0
  logic signed [31:0] shadow_value [DEPTH];
  logic signed [31:0] shadow_rank [DEPTH];
  int shadow_count = 0;

  bpq_pkg::rsp_t expected_rsp_q [$];
  int errors = 0;
  int idle_cycles = 0;
  bit idle_en = 1'b1;
  bit hold_pending = 1'b0;

  bounded_priority_queue #(.CAPACITY(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bpq_pkg::rsp_t predict_response(bpq_pkg::req_t r);
    bpq_pkg::rsp_t o;
    int pos;
    int i;
    o = '0;
    case (r.mode)
      bpq_pkg::MODE_ENQ: begin
        if (shadow_count >= DEPTH) begin
          o.status = bpq_pkg::STATUS_FULL;
        end else begin
          // new entry goes behind every entry of equal or higher rank
          pos = 0;
          while (pos < shadow_count && r.item_rank <= shadow_rank[pos]) pos++;
          for (i = shadow_count; i > pos; i--) begin
            shadow_value[i] = shadow_value[i - 1];
            shadow_rank[i] = shadow_rank[i - 1];
          end
          shadow_value[pos] = r.item_value;
          shadow_rank[pos] = r.item_rank;
          shadow_count++;
          o.status = bpq_pkg::STATUS_OK;
        end
      end
      bpq_pkg::MODE_DEQ, bpq_pkg::MODE_PEEK: begin
        if (shadow_count == 0) begin
          o.status = bpq_pkg::STATUS_EMPTY;
        end else begin
          o.status = bpq_pkg::STATUS_OK;
          o.front_value = shadow_value[0];
          o.front_rank = shadow_rank[0];
          if (r.mode == bpq_pkg::MODE_DEQ) begin
            for (i = 1; i < shadow_count; i++) begin
              shadow_value[i - 1] = shadow_value[i];
              shadow_rank[i - 1] = shadow_rank[i];
            end
            shadow_count--;
          end
        end
      end
      default: o.status = bpq_pkg::STATUS_OK;
    endcase
    o.fill_level = 5'(shadow_count);
    return o;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_en) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [31:0] pick_rank();
    int r;
    r = $urandom_range(0, 9);
    // narrow range gives many equal ranks
    if (r < 5) return 32'(int'($urandom_range(0, 6)) - 3);
    if (r == 5) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7fff_ffff;
        1: return 32'sh8000_0000;
        2: return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic bpq_pkg::req_t make_req(logic [1:0] mode, logic signed [31:0] value,
                                             logic signed [31:0] rank);
    bpq_pkg::req_t r;
    r.mode = mode;
    r.item_value = value;
    r.item_rank = rank;
    return r;
  endfunction

  // valid stays high after acceptance so the next item can follow without a bubble
  task automatic send_request(input bpq_pkg::req_t item);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    expected_rsp_q.push_back(predict_response(item));
  endtask

  task automatic log_error(input string msg);
    errors++;
    if (errors <= MAX_SHOWN) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    bpq_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsp_q.size() == 0) begin
        log_error($sformatf("unexpected item: status %0d value %0d rank %0d fill %0d",
                            rsp.status, rsp.front_value, rsp.front_rank, rsp.fill_level));
      end else begin
        want = expected_rsp_q.pop_front();
        if (rsp.status !== want.status || rsp.front_value !== want.front_value ||
            rsp.front_rank !== want.front_rank || rsp.fill_level !== want.fill_level)
          log_error($sformatf(
            "mismatch: expected status %0d value %0d rank %0d fill %0d, got %0d %0d %0d %0d",
            want.status, want.front_value, want.front_rank, want.fill_level,
            rsp.status, rsp.front_value, rsp.front_rank, rsp.fill_level));
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin : rsp_side
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        rsp_ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic test_directed();
    logic signed [31:0] ranks [16];
    logic signed [31:0] values [16];
    int i;
    ranks = '{0, 0, 32'sh7fff_ffff, 32'sh8000_0000, -1, 1, 32'sh7fff_ffff, 32'sh8000_0000,
              5, 5, 5, -5, 100, -100, 7, 0};
    values = '{32'sh7fff_ffff, 32'sh8000_0000, 0, -1, 11, 12, 13, 14,
               15, 16, 17, 18, 19, 20, 21, 22};
    // empty queue
    send_request(make_req(bpq_pkg::MODE_PEEK, 32'sd1, 32'sd1));
    send_request(make_req(bpq_pkg::MODE_DEQ, 32'sd1, 32'sd1));
    send_request(make_req(bpq_pkg::MODE_UNUSED, 32'sd1, 32'sd1));
    for (i = 0; i < 16; i++) send_request(make_req(bpq_pkg::MODE_ENQ, values[i], ranks[i]));
    // full queue
    send_request(make_req(bpq_pkg::MODE_ENQ, 32'sd99, 32'sh7fff_ffff));
    send_request(make_req(bpq_pkg::MODE_UNUSED, -32'sd1, -32'sd1));
    send_request(make_req(bpq_pkg::MODE_PEEK, 32'sd0, 32'sd0));
    for (i = 0; i < 3; i++) send_request(make_req(bpq_pkg::MODE_DEQ, $urandom, $urandom));
  endtask

  task automatic test_output_backpressure();
    int i;
    idle_en = 1'b0;
    hold_pending = 1'b1;
    // sender keeps offering while the receiver holds off
    for (i = 0; i < 24; i++) send_request(make_req(bpq_pkg::MODE_ENQ, $urandom, pick_rank()));
    for (i = 0; i < 24; i++) send_request(make_req(bpq_pkg::MODE_DEQ, $urandom, $urandom));
    idle_en = 1'b1;
  endtask

  task automatic test_random();
    int enq_pct [4];
    int pct;
    int sent;
    int r;
    bpq_pkg::req_t item;
    enq_pct = '{20, 50, 80, 95};
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      // each phase biases toward filling, draining or churning
      if (sent % PHASE_LEN == 0) begin
        pct = enq_pct[$urandom_range(0, 3)];
        idle_en = ($urandom_range(0, 3) != 0);
      end
      r = $urandom_range(0, 99);
      item.item_value = $urandom;
      item.item_rank = pick_rank();
      if (r < 3) begin
        item.mode = bpq_pkg::MODE_UNUSED;
      end else if ($urandom_range(0, 99) < pct) begin
        item.mode = bpq_pkg::MODE_ENQ;
      end else begin
        item.mode = ($urandom_range(0, 3) == 0) ? bpq_pkg::MODE_PEEK : bpq_pkg::MODE_DEQ;
      end
      send_request(item);
      if (item.mode != bpq_pkg::MODE_UNUSED) sent++;
    end
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_output_backpressure();
    test_random();
    req_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    errors += expected_rsp_q.size();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
